FILE: hdl/smmd_pkg.sv
package smmd_pkg;

   // Delimiters and base64 alphabet anchors
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   localparam logic [6:0] DIGIT_LOWER_BASE = 7'd26;
   localparam logic [6:0] DIGIT_NUM_BASE   = 7'd52;
   localparam logic [6:0] DIGIT_PLUS       = 7'd62;
   localparam logic [6:0] DIGIT_SLASH      = 7'd63;
   localparam logic [6:0] NO_DIGIT         = 7'd64;

   // VLQ shift handling
   localparam int SHIFT_LIMIT = 32;
   localparam int SHIFT_MAX   = 35;
   localparam int DIGIT_STEP  = 5;

   // Segment value counts
   localparam int SEG_VALUES     = 5;
   localparam int COUNT_MAX      = 6;
   localparam int COUNT_COL_ONLY = 1;
   localparam int COUNT_SHORT    = 4;
   localparam int COUNT_FULL     = 5;

   // Result queue depth, power of two, at least 4
   localparam int RSP_DEPTH = 4;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_BAD_CHAR,
      STATUS_OPEN_DIGIT,
      STATUS_EMPTY_SEG,
      STATUS_BAD_COUNT
   } status_type;

   typedef struct packed {
      logic [31:0] gen_row;
      logic [31:0] gen_col;
      logic [31:0] src_index;
      logic [31:0] src_row;
      logic [31:0] src_col;
      logic [31:0] name_index;
   } pos_type;

   typedef struct packed {
      logic       kind;
      pos_type    pos;
      status_type status;
      logic       final_item;
   } result_type;

   // Up to two results per character: a record, then the end-of-text report
   typedef struct packed {
      logic       rec_valid;
      result_type rec;
      logic       rpt_valid;
      result_type rpt;
   } push_type;

   function automatic logic [6:0] b64_digit(input logic [7:0] c);
      logic [6:0] d;
      d = NO_DIGIT;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = 7'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = 7'(c - CHAR_LOWER_A) + DIGIT_LOWER_BASE;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 7'(c - CHAR_ZERO) + DIGIT_NUM_BASE;
      end else if (c == CHAR_PLUS) begin
         d = DIGIT_PLUS;
      end else if (c == CHAR_SLASH) begin
         d = DIGIT_SLASH;
      end
      return d;
   endfunction

endpackage

FILE: hdl/smmd_req_if.sv
interface smmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, char_code, end_of_text, input ready);
   modport sink (input valid, char_code, end_of_text, output ready);
endinterface

FILE: hdl/smmd_rsp_if.sv
interface smmd_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] gen_row;
   logic signed [31:0] gen_col;
   logic signed [31:0] src_index;
   logic signed [31:0] src_row;
   logic signed [31:0] src_col;
   logic signed [31:0] name_index;
   logic [2:0]         status;
   logic               final_item;

   modport source (output valid, kind, gen_row, gen_col, src_index, src_row, src_col,
                   name_index, status, final_item, input ready);
   modport sink (input valid, kind, gen_row, gen_col, src_index, src_row, src_col,
                 name_index, status, final_item, output ready);
endinterface

FILE: hdl/source_map_mapping_decoder_top.sv
// Source map mappings decoder.
// req_chan carries one byte of the mappings text per transfer (char_code) and
// end_of_text on the last byte. rsp_chan carries mapping records (kind 0) with
// absolute positions and, after the last byte, one end-of-text report (kind 1,
// final_item 1) with the running position and the first error status.
// A result is written into the result queue when its byte is taken and is
// offered from the queue head; when the last byte also closes a mapping,
// the record comes first and the report after it.
// Throughput: one byte per cycle while the queue has room. The decode of a
// byte is one pass through the digit table, the VLQ shift-add and the position
// adders in smmd_core, written into a four-entry result queue. req_chan.ready is
// high while the queue holds at most two results, so a record plus report always fits.
// Reset (synchronous) clears positions, digit and segment state, the error
// status and the queue. State also returns to reset after every end of text.
// When the receiver stalls, results wait in the queue; bytes keep being
// taken until the queue has no room for two more results.
module source_map_mapping_decoder_top (
   input logic       clock,
   input logic       reset,
   smmd_req_if.sink  req_chan,
   smmd_rsp_if.source rsp_chan
);
   import smmd_pkg::*;

   push_type push;
   logic     room;
   logic     accept;

   // Take a byte only when the queue can hold what it may produce
   assign req_chan.ready = room;
   assign accept         = req_chan.valid && req_chan.ready;

   smmd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_chan.char_code),
      .end_of_text (req_chan.end_of_text),
      .push        (push)
   );

   smmd_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: hdl/smmd_core.sv
module smmd_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         char_code,
   input  logic               end_of_text,
   output smmd_pkg::push_type push
);
   import smmd_pkg::*;

   pos_type     pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  shift_ff, shift_in;
   logic        pending_ff, pending_in;
   logic [31:0] vals_ff [SEG_VALUES];
   logic [31:0] vals_in [SEG_VALUES];
   logic [2:0]  count_ff, count_in;
   logic        nonempty_ff, nonempty_in;
   status_type  err_ff, err_in;

   logic [6:0]  digit;
   logic        is_digit, is_comma, is_semi, close_go, clear_seg;
   logic [31:0] acc_sum, mag, value;

   always_comb begin
      digit    = b64_digit(char_code);
      is_digit = (digit != NO_DIGIT);
      is_comma = (char_code == CHAR_COMMA);
      is_semi  = (char_code == CHAR_SEMI);

      pos_in      = pos_ff;
      acc_in      = acc_ff;
      shift_in    = shift_ff;
      pending_in  = pending_ff;
      vals_in     = vals_ff;
      count_in    = count_ff;
      nonempty_in = nonempty_ff;
      err_in      = err_ff;
      push        = '0;
      close_go    = 1'b0;
      clear_seg   = 1'b0;

      // Groups at shift 32 or more add nothing
      acc_sum = acc_ff + ((shift_ff < 6'(SHIFT_LIMIT)) ?
                          (32'(digit[4:0]) << shift_ff[4:0]) : 32'd0);
      mag     = {1'b0, acc_sum[31:1]};
      value   = acc_sum[0] ? (32'd0 - mag) : mag;

      if (accept) begin
         if (err_ff == STATUS_OK) begin
            if (is_comma) begin
               if (!nonempty_ff) err_in = STATUS_EMPTY_SEG;
            end else if (!is_semi) begin
               if (!is_digit) begin
                  err_in = STATUS_BAD_CHAR;
               end else begin
                  nonempty_in = 1'b1;
                  acc_in      = acc_sum;
                  if (digit[5]) begin
                     shift_in   = (shift_ff > 6'(SHIFT_MAX - DIGIT_STEP)) ?
                                  6'(SHIFT_MAX) : shift_ff + 6'(DIGIT_STEP);
                     pending_in = 1'b1;
                  end else begin
                     if (count_ff < 3'(SEG_VALUES)) vals_in[count_ff] = value;
                     if (count_ff < 3'(COUNT_MAX)) count_in = count_ff + 3'd1;
                     acc_in     = '0;
                     shift_in   = '0;
                     pending_in = 1'b0;
                  end
               end
            end
         end

         // Close the open segment at a delimiter or at end of text
         close_go = (err_in == STATUS_OK) && nonempty_in &&
                    (is_comma || is_semi || end_of_text);
         if (close_go) begin
            if (pending_in) begin
               err_in = STATUS_OPEN_DIGIT;
            end else if (count_in == 3'(COUNT_COL_ONLY)) begin
               pos_in.gen_col = pos_ff.gen_col + vals_in[0];
               clear_seg      = 1'b1;
            end else if (count_in == 3'(COUNT_SHORT) || count_in == 3'(COUNT_FULL)) begin
               pos_in.gen_col   = pos_ff.gen_col + vals_in[0];
               pos_in.src_index = pos_ff.src_index + vals_in[1];
               pos_in.src_row   = pos_ff.src_row + vals_in[2];
               pos_in.src_col   = pos_ff.src_col + vals_in[3];
               if (count_in == 3'(COUNT_FULL)) begin
                  pos_in.name_index = pos_ff.name_index + vals_in[4];
               end
               push.rec_valid = 1'b1;
               push.rec       = '{kind: KIND_RECORD, pos: pos_in, status: STATUS_OK,
                                  final_item: 1'b0};
               clear_seg      = 1'b1;
            end else begin
               err_in = STATUS_BAD_COUNT;
            end
         end
         if (clear_seg) begin
            acc_in      = '0;
            shift_in    = '0;
            pending_in  = 1'b0;
            count_in    = '0;
            nonempty_in = 1'b0;
         end

         // Advance the generated row
         if (is_semi && err_in == STATUS_OK) begin
            pos_in.gen_row = pos_in.gen_row + 32'd1;
            pos_in.gen_col = '0;
         end

         if (end_of_text) begin
            push.rpt_valid = 1'b1;
            push.rpt       = '{kind: KIND_REPORT, pos: pos_in, status: err_in,
                               final_item: 1'b1};
            pos_in         = '0;
            acc_in         = '0;
            shift_in       = '0;
            pending_in     = 1'b0;
            count_in       = '0;
            nonempty_in    = 1'b0;
            err_in         = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         acc_ff      <= '0;
         shift_ff    <= '0;
         pending_ff  <= 1'b0;
         count_ff    <= '0;
         nonempty_ff <= 1'b0;
         err_ff      <= STATUS_OK;
      end else begin
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         shift_ff    <= shift_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         nonempty_ff <= nonempty_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals_in;
   end

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |=> err_ff == STATUS_OK && !nonempty_ff && count_ff == 3'd0)
      else $error("state not cleared after end of text");

   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |-> !push.rec_valid && !push.rpt_valid)
      else $error("result pushed without an accepted character");

   a_no_record_after_error: assert property (@(posedge clock) disable iff (reset)
      push.rec_valid |-> err_ff == STATUS_OK)
      else $error("mapping record emitted after an error");

endmodule

FILE: hdl/smmd_rsp_queue.sv
module smmd_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  smmd_pkg::push_type push,
   output logic               room,
   smmd_rsp_if.source         rsp_chan
);
   import smmd_pkg::*;

   localparam int PtrW = $clog2(RSP_DEPTH);

   result_type        slots [RSP_DEPTH];
   result_type        head_item;
   logic [PtrW-1:0]   head_ff, head_in, tail_ff, tail_in, second_slot;
   logic [PtrW:0]     count_ff, count_in;
   logic              pop;

   always_comb begin
      pop         = rsp_chan.valid && rsp_chan.ready;
      second_slot = push.rec_valid ? PtrW'(tail_ff + 1'b1) : tail_ff;
      tail_in     = tail_ff + PtrW'(push.rec_valid) + PtrW'(push.rpt_valid);
      head_in     = head_ff + PtrW'(pop);
      count_in    = count_ff + (PtrW+1)'(push.rec_valid) + (PtrW+1)'(push.rpt_valid)
                    - (PtrW+1)'(pop);
      // Keep space for a record and a report
      room        = (count_ff <= (PtrW+1)'(RSP_DEPTH - 2));
      head_item   = slots[head_ff];
   end

   always_ff @(posedge clock) begin
      if (push.rec_valid) slots[tail_ff] <= push.rec;
      if (push.rpt_valid) slots[second_slot] <= push.rpt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.kind       = head_item.kind;
   assign rsp_chan.gen_row    = head_item.pos.gen_row;
   assign rsp_chan.gen_col    = head_item.pos.gen_col;
   assign rsp_chan.src_index  = head_item.pos.src_index;
   assign rsp_chan.src_row    = head_item.pos.src_row;
   assign rsp_chan.src_col    = head_item.pos.src_col;
   assign rsp_chan.name_index = head_item.pos.name_index;
   assign rsp_chan.status     = head_item.status;
   assign rsp_chan.final_item = head_item.final_item;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(RSP_DEPTH))
      else $error("result queue count out of range");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.rec_valid || push.rpt_valid |-> room)
      else $error("push into result queue without room");

   a_report_lands: assert property (@(posedge clock) disable iff (reset)
      push.rpt_valid && !pop |=> count_ff != '0)
      else $error("end of text report lost");

endmodule

FILE: tb/smmd_checker.sv
module smmd_checker (
   input  logic clock,
   input  logic reset,
   smmd_req_if  req_mon,
   smmd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   owed_count,
   output int   records_seen,
   output int   reports_seen,
   output int   error_reports
);
   import smmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Running decode state, kept apart from the block
   pos_type     cur_pos;
   logic [31:0] vlq_acc;
   logic [5:0]  vlq_shift;
   logic        open_digit;
   logic [31:0] seg_val [SEG_VALUES];
   logic [2:0]  nvals;
   logic        seg_nonempty;
   status_type  first_err;

   result_type  decoded_results [$];
   int          mismatches;

   function automatic logic [6:0] digit_of(input logic [7:0] c);
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) return 7'(c - CHAR_UPPER_A);
      if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) return 7'(c - CHAR_LOWER_A) + DIGIT_LOWER_BASE;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) return 7'(c - CHAR_ZERO) + DIGIT_NUM_BASE;
      if (c == CHAR_PLUS) return DIGIT_PLUS;
      if (c == CHAR_SLASH) return DIGIT_SLASH;
      return NO_DIGIT;
   endfunction

   task automatic clear_segment();
      vlq_acc      = '0;
      vlq_shift    = '0;
      open_digit   = 1'b0;
      nvals        = '0;
      seg_nonempty = 1'b0;
   endtask

   task automatic clear_all();
      cur_pos   = '0;
      first_err = STATUS_OK;
      foreach (seg_val[i]) seg_val[i] = '0;
      clear_segment();
   endtask

   task automatic flag_error(input status_type code);
      if (first_err == STATUS_OK) first_err = code;
   endtask

   task automatic queue_result(input logic kind, input status_type st);
      result_type r;
      r.kind       = kind;
      r.pos        = cur_pos;
      r.status     = st;
      r.final_item = kind;
      decoded_results.insert(decoded_results.size(), r);
   endtask

   task automatic close_segment();
      if (open_digit) begin
         flag_error(STATUS_OPEN_DIGIT);
      end else if (nvals == COUNT_COL_ONLY) begin
         cur_pos.gen_col += seg_val[0];
         clear_segment();
      end else if (nvals == COUNT_SHORT || nvals == COUNT_FULL) begin
         cur_pos.gen_col   += seg_val[0];
         cur_pos.src_index += seg_val[1];
         cur_pos.src_row   += seg_val[2];
         cur_pos.src_col   += seg_val[3];
         if (nvals == COUNT_FULL) cur_pos.name_index += seg_val[4];
         queue_result(KIND_RECORD, STATUS_OK);
         clear_segment();
      end else begin
         flag_error(STATUS_BAD_COUNT);
      end
   endtask

   task automatic take_digit(input logic [5:0] d);
      logic [31:0] mag;
      logic [31:0] v;
      seg_nonempty = 1'b1;
      if (vlq_shift < SHIFT_LIMIT) vlq_acc += {27'd0, d[4:0]} << vlq_shift;
      if (d[5]) begin
         vlq_shift  = (vlq_shift + DIGIT_STEP > SHIFT_MAX) ? 6'(SHIFT_MAX)
                                                           : 6'(vlq_shift + DIGIT_STEP);
         open_digit = 1'b1;
      end else begin
         mag = vlq_acc >> 1;
         v   = vlq_acc[0] ? -mag : mag;
         if (nvals < SEG_VALUES) seg_val[nvals] = v;
         if (nvals < COUNT_MAX) nvals = nvals + 3'd1;
         vlq_acc    = '0;
         vlq_shift  = '0;
         open_digit = 1'b0;
      end
   endtask

   // One byte of mappings text: update the position and queue what it produces
   task automatic decode_byte(input logic [7:0] c, input logic eot);
      logic [6:0] d;
      if (first_err == STATUS_OK) begin
         if (c == CHAR_COMMA) begin
            if (!seg_nonempty) flag_error(STATUS_EMPTY_SEG);
            else close_segment();
         end else if (c == CHAR_SEMI) begin
            if (seg_nonempty) close_segment();
            if (first_err == STATUS_OK) begin
               cur_pos.gen_row += 32'd1;
               cur_pos.gen_col = '0;
            end
         end else begin
            d = digit_of(c);
            if (d == NO_DIGIT) flag_error(STATUS_BAD_CHAR);
            else take_digit(d[5:0]);
         end
      end
      if (eot) begin
         if (first_err == STATUS_OK && seg_nonempty) close_segment();
         queue_result(KIND_REPORT, first_err);
         clear_all();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (decoded_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with nothing owed, kind %0d status %0d",
                     $realtime, rsp_mon.kind, rsp_mon.status);
      end else begin
         want = decoded_results.pop_front();
         check_field("kind",       32'(want.kind),       32'(rsp_mon.kind));
         check_field("gen_row",    want.pos.gen_row,     rsp_mon.gen_row);
         check_field("gen_col",    want.pos.gen_col,     rsp_mon.gen_col);
         check_field("src_index",  want.pos.src_index,   rsp_mon.src_index);
         check_field("src_row",    want.pos.src_row,     rsp_mon.src_row);
         check_field("src_col",    want.pos.src_col,     rsp_mon.src_col);
         check_field("name_index", want.pos.name_index,  rsp_mon.name_index);
         check_field("status",     32'(want.status),     32'(rsp_mon.status));
         check_field("final_item", 32'(want.final_item), 32'(rsp_mon.final_item));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_all();
         decoded_results.delete();
      end else begin
         // results are registered in the queue before they leave, so check before predicting
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
            if (rsp_mon.kind == KIND_REPORT) begin
               reports_seen <= reports_seen + 1;
               if (rsp_mon.status != STATUS_OK) error_reports <= error_reports + 1;
            end else begin
               records_seen <= records_seen + 1;
            end
         end
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.char_code, req_mon.end_of_text);
      end
      owed_count <= decoded_results.size();
      fail_count <= mismatches;
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import smmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 550;
   localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int IDLE_LIMIT   = 3000;  // cycles with no transfer before giving up
   localparam int HOLD_AFTER   = 200;   // random bytes sent before the long hold-off
   localparam int HOLD_TEXTS   = 4;     // texts sent without a drain once the hold-off is asked

   logic clock = 1'b0;
   logic reset;

   smmd_req_if req_chan ();
   smmd_rsp_if rsp_chan ();

   int fail_count;
   int owed_count;
   int records_seen;
   int reports_seen;
   int error_reports;

   // Stimulus bookkeeping
   logic [7:0] text_buf [$];
   int         bytes_sent;
   int         texts_sent;
   int         burst_left;
   int         holds_wanted;
   int         idle_cycles;

   source_map_mapping_decoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   smmd_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .owed_count    (owed_count),
      .records_seen  (records_seen),
      .reports_seen  (reports_seen),
      .error_reports (error_reports)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Map a 6-bit VLQ digit back to its base64 character
   function automatic logic [7:0] digit_char(input logic [5:0] d);
      if (d < DIGIT_LOWER_BASE) return CHAR_UPPER_A + 8'(d);
      if (d < DIGIT_NUM_BASE) return CHAR_LOWER_A + 8'(d) - 8'(DIGIT_LOWER_BASE);
      if (d < DIGIT_PLUS) return CHAR_ZERO + 8'(d) - 8'(DIGIT_NUM_BASE);
      if (d == DIGIT_PLUS) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Mostly small deltas, now and then wide ones and the 32-bit corners
   function automatic logic [31:0] pick_raw();
      logic [31:0] corners [6];
      corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF};
      case ($urandom_range(0, 9))
         6, 7:    return $urandom_range(0, 2000);
         8:       return $urandom();
         9:       return corners[$urandom_range(0, 5)];
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   // Mostly legal counts (1, 4, 5); a few 2/3 and over-long segments
   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 6) return COUNT_COL_ONLY;
      if (r < 12) return COUNT_SHORT;
      if (r < 18) return COUNT_FULL;
      if (r == 18) return $urandom_range(2, 3);
      return $urandom_range(COUNT_MAX, COUNT_MAX + 1);
   endfunction

   // Append one byte to the text being built
   task automatic append_byte(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   // Encode one accumulator value as VLQ digits; the long form pads past bit 31
   task automatic add_value(input logic [31:0] raw, input bit long_form);
      logic [5:0] d;
      if (long_form) begin
         for (int i = 0; i < 7; i++) begin
            append_byte(digit_char({1'b1, raw[4:0]}));
            raw = raw >> 5;
         end
         repeat ($urandom_range(0, 3)) append_byte(digit_char({1'b1, 5'($urandom())}));
         append_byte(digit_char({1'b0, 5'($urandom())}));
      end else begin
         do begin
            d = {1'b0, raw[4:0]};
            raw = raw >> 5;
            if (raw != 0) d[5] = 1'b1;
            append_byte(digit_char(d));
         end while (raw != 0);
      end
   endtask

   // Build one mappings text: lines of segments, sometimes with one flaw
   task automatic build_random_text();
      int lines;
      int segs;
      int nv;
      text_buf.delete();
      if ($urandom_range(0, 19) == 0) begin
         // pure noise, any byte value
         repeat ($urandom_range(1, 6)) append_byte(8'($urandom()));
         return;
      end
      lines = $urandom_range(1, 3);
      for (int l = 0; l < lines; l++) begin
         segs = $urandom_range(0, 4);
         for (int s = 0; s < segs; s++) begin
            if (s > 0) append_byte(CHAR_COMMA);
            nv = pick_count();
            repeat (nv) add_value(pick_raw(), $urandom_range(0, 19) == 0);
         end
         if (l < lines - 1 || $urandom_range(0, 2) == 0) append_byte(CHAR_SEMI);
      end
      if (text_buf.size() == 0) append_byte(CHAR_SEMI);
      case ($urandom_range(0, 9))
         0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom());
         1: text_buf.insert($urandom_range(0, text_buf.size()), CHAR_COMMA);
         2: if (text_buf.size() > 1) void'(text_buf.pop_back());  // may leave a digit open
         default: ;
      endcase
   endtask

   // Offer one byte and hold it until the block takes it; gaps come between bursts
   task automatic send_byte(input logic [7:0] c, input logic eot);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0, 1, 2: gap = 0;
            3, 4:    gap = $urandom_range(1, 3);
            default: gap = $urandom_range(5, 30);
         endcase
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.char_code   <= c;
      req_chan.end_of_text <= eot;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // Send the buffered text, end_of_text on its last byte
   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
      texts_sent++;
      text_buf.delete();
   endtask

   // Drop valid and wait for every owed result; owed_count is registered, so let it catch up first
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
   endtask

   // Receiver: switch between always ready, random, mostly stalled and a fixed pattern
   initial begin : rsp_pacer
      int mode;
      int span;
      int holds_done;
      int cyc;
      holds_done = 0;
      cyc = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         repeat (span) begin
            @(posedge clock);
            cyc++;
            if (holds_wanted != holds_done) begin
               // long hold-off: let the block fill up and stall its input
               holds_done++;
               rsp_chan.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ((cyc / 3) % 2) == 0;
            endcase
         end
      end
   end

   // Watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results owed",
                  idle_cycles, owed_count);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int random_start;
      int hold_texts;
      bit hold_asked;
      req_chan.valid       <= 1'b0;
      req_chan.char_code   <= '0;
      req_chan.end_of_text <= 1'b0;
      reset                <= 1'b1;
      bytes_sent   = 0;
      texts_sent   = 0;
      burst_left   = 0;
      holds_wanted = 0;
      hold_texts   = 0;
      hold_asked   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts
      // widest positive column delta with short deltas after: record, then report
      add_value(32'hFFFF_FFFE, 1'b0);
      push_string("DAC");
      send_text();
      // two values before a semicolon: bad count
      push_string("AA;");
      send_text();
      // a byte outside the alphabet, top bit set
      append_byte(8'hFF);
      push_string("A");
      send_text();
      // digit left open at end of text, then at a comma
      push_string("g");
      send_text();
      push_string("g,");
      send_text();
      // comma with nothing before it
      push_string(",");
      send_text();
      // long digit: groups past bit 31 add nothing
      push_string("///////D");
      send_text();
      // empty lines are legal and advance the row
      push_string(";;");
      send_text();
      drain();

      // Random texts, with drained pauses and one long receiver hold-off
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         build_random_text();
         send_text();
         // keep offering texts while the receiver holds off, so the block fills up
         if (hold_texts > 0) begin
            hold_texts--;
         end else if (texts_sent % 9 == 0) begin
            drain();
         end
         if (!hold_asked && bytes_sent - random_start > HOLD_AFTER) begin
            hold_asked = 1'b1;
            hold_texts = HOLD_TEXTS;
            holds_wanted++;
         end
      end

      // Wind down: wait for every owed result, then wait for strays
      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d bytes in %0d texts; %0d records and %0d reports checked",
               bytes_sent, texts_sent, records_seen, reports_seen);
      $display("%0d texts ended with an error status", error_reports);
      if (owed_count != 0) $display("%0d results never arrived", owed_count);
      if (fail_count == 0 && owed_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
